/* rtl/core/sitda_pkg.sv */
// Package for the signed integer to decimal ASCII unit.
// Holds the sequencer state type and the character constants.
// No dependencies.
package sitda_pkg;

   // ASCII codes that the unit emits.
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // Decimal digit correction threshold and offset for shift-add-3.
   localparam logic [3:0] DABBLE_LIMIT  = 4'd5;
   localparam logic [3:0] DABBLE_OFFSET = 4'd3;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

/* rtl/core/sitda_dabble.sv */
// One shift-add-3 step of the binary to BCD conversion.
// Depends on sitda_pkg for the digit correction constants.
// The unit is shared by every bit of the magnitude, one bit per cycle.
module sitda_dabble #(
   parameter int NUM_DIGITS = 10
) (
   input  logic [NUM_DIGITS*4-1:0] bcd_in,
   input  logic                    bit_in,
   output logic [NUM_DIGITS*4-1:0] bcd_out
);

   logic [NUM_DIGITS*4-1:0] adjusted;

   // Correct every digit that would overflow when doubled.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_in[i*4 +: 4] >= sitda_pkg::DABBLE_LIMIT) begin
            adjusted[i*4 +: 4] = bcd_in[i*4 +: 4] + sitda_pkg::DABBLE_OFFSET;
         end else begin
            adjusted[i*4 +: 4] = bcd_in[i*4 +: 4];
         end
      end
   end

   // Double and shift in the next magnitude bit.
   assign bcd_out = {adjusted[NUM_DIGITS*4-2:0], bit_in};

endmodule

/* rtl/core/sitda_digit_len.sv */
// Leading digit search: number of significant digits in a BCD word.
// No package dependencies. A word of all zeros counts as one digit.
module sitda_digit_len #(
   parameter int NUM_DIGITS = 10,
   parameter int LEN_W      = 4
) (
   input  logic [NUM_DIGITS*4-1:0] bcd,
   output logic [LEN_W-1:0]        len
);

   // The highest nonzero digit sets the length.
   always_comb begin
      len = LEN_W'(1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd[i*4 +: 4] != 4'd0) begin
            len = LEN_W'(i + 1);
         end
      end
   end

endmodule

/* rtl/core/signed_int_to_decimal_ascii_unit.sv */
// Top level of the signed integer to decimal ASCII unit.
// Depends on sitda_pkg, sitda_dabble and sitda_digit_len.
//
// The unit takes one signed VALUE_BITS-bit integer when start is high and busy is low,
// and returns its decimal text, most significant character first, one character per
// beat on the rsp_ ports, each beat marked by rsp_strobe for one cycle. A negative
// number starts with '-', zero gives a single '0', and every beat carries the total
// character count, with rsp_last set on the final one. The receiver cannot stall:
// the characters of one number come on consecutive cycles. An item keeps the unit
// busy through shift-add-3 on each magnitude bit in the shared BCD step unit, the
// leading digit search, and then the emission of its characters. The last character
// is on the ports in the first cycle with busy low, so the next number can be taken
// at the edge that ends that cycle.
module signed_int_to_decimal_ascii_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_ascii_char,
   output logic [3:0]                   rsp_char_count,
   output logic                         rsp_last
);

   // Digits needed for the magnitude: floor(VALUE_BITS * log10(2)) + 1.
   localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_W      = NUM_DIGITS * 4;
   localparam int DIG_W      = $clog2(NUM_DIGITS);
   localparam int LEN_RAW_W  = $clog2(NUM_DIGITS + 2);
   localparam int LEN_W      = (LEN_RAW_W > 4) ? LEN_RAW_W : 4;
   localparam int BIT_W      = $clog2(VALUE_BITS);

   sitda_pkg::state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BIT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic                  neg_ff, neg_in;
   logic                  sign_pend_ff, sign_pend_in;
   logic [DIG_W-1:0]      dptr_ff, dptr_in;
   logic [LEN_W-1:0]      total_ff, total_in;

   logic                  strobe_ff, strobe_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic [VALUE_BITS-1:0] raw;
   logic [BCD_W-1:0]      bcd_step;
   logic [LEN_W-1:0]      digit_len;
   logic [3:0]            cur_digit;
   logic                  accept;

   assign accept    = start && (state_ff == sitda_pkg::ST_IDLE);
   assign raw       = VALUE_BITS'(req_value);
   assign cur_digit = bcd_ff[4*dptr_ff +: 4];

   // Shared BCD step unit.
   sitda_dabble #(
      .NUM_DIGITS(NUM_DIGITS)
   ) u_dabble (
      .bcd_in (bcd_ff),
      .bit_in (mag_ff[VALUE_BITS-1]),
      .bcd_out(bcd_step)
   );

   // Significant digit count of the finished BCD word.
   sitda_digit_len #(
      .NUM_DIGITS(NUM_DIGITS),
      .LEN_W     (LEN_W)
   ) u_digit_len (
      .bcd(bcd_ff),
      .len(digit_len)
   );

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      dptr_in      = dptr_ff;
      total_in     = total_ff;
      strobe_in    = 1'b0;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         sitda_pkg::ST_IDLE: begin
            if (accept) begin
               neg_in     = raw[VALUE_BITS-1];
               mag_in     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
               bcd_in     = '0;
               bit_cnt_in = BIT_W'(VALUE_BITS - 1);
               state_in   = sitda_pkg::ST_CONV;
            end
         end
         sitda_pkg::ST_CONV: begin
            bcd_in = bcd_step;
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               state_in = sitda_pkg::ST_SCAN;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         sitda_pkg::ST_SCAN: begin
            dptr_in      = DIG_W'(digit_len - 1'b1);
            total_in     = digit_len + LEN_W'(neg_ff);
            sign_pend_in = neg_ff;
            state_in     = sitda_pkg::ST_EMIT;
         end
         sitda_pkg::ST_EMIT: begin
            strobe_in = 1'b1;
            if (sign_pend_ff) begin
               char_in      = sitda_pkg::CHAR_MINUS;
               last_in      = 1'b0;
               sign_pend_in = 1'b0;
            end else begin
               char_in = sitda_pkg::CHAR_ZERO + {4'd0, cur_digit};
               last_in = (dptr_ff == '0);
               if (dptr_ff == '0) begin
                  state_in = sitda_pkg::ST_IDLE;
               end else begin
                  dptr_in = dptr_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = sitda_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sitda_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      bcd_ff       <= bcd_in;
      bit_cnt_ff   <= bit_cnt_in;
      neg_ff       <= neg_in;
      sign_pend_ff <= sign_pend_in;
      dptr_ff      <= dptr_in;
      total_ff     <= total_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
   end

   // Outputs.
   assign busy           = (state_ff != sitda_pkg::ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_char_count = total_ff[3:0];
   assign rsp_last       = last_ff;

   // A character beat only follows a cycle of the emit state.
   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == sitda_pkg::ST_EMIT))
      else $error("character beat without emit state");

   // An accepted number makes the unit busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted number did not raise busy");

   // The final character frees the unit; any other character keeps it busy.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last == !busy))
      else $error("last flag and busy disagree");

   // The character count holds across the beats of one number.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe)) |-> $stable(rsp_char_count))
      else $error("character count changed within one number");

endmodule
